// File: sv/sorted_position_range_query_macros.svh
// assertion helpers used by spq_core
`ifndef SORTED_POSITION_RANGE_QUERY_MACROS_SVH
`define SORTED_POSITION_RANGE_QUERY_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 32;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] position_value;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_stop;
    logic [POS_W-1:0] index_offset;
  } spq_in_t;

  // result item
  typedef struct packed {
    logic [POS_W-1:0] first_index;
    logic [POS_W-1:0] end_index;
  } spq_out_t;

  // table memory request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [POS_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } spq_ram_req_t;

endpackage

// File: sv/spq_ram.sv
`timescale 1ns / 1ps
module spq_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/spq_core.sv
`timescale 1ns / 1ps
`include "sorted_position_range_query_macros.svh"
module spq_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spq_pkg::spq_in_t      in_item,
  output spq_pkg::spq_ram_req_t ram_req,
  input  logic [31:0]           ram_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output spq_pkg::spq_out_t     res_item
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOP = 3'b010,
    ST_CMP  = 3'b100
  } spq_state_t;

  spq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0] stop_r, stop_nxt;
  logic [POS_W-1:0] offset_r, offset_nxt;

  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] mid;
  logic [CNT_W:0]   lo_plus_len;

  // bisection step values
  assign half        = len_r >> 1;
  assign mid         = lo_r + half;
  assign lo_plus_len = {1'b0, lo_r} + {1'b0, len_r};

  assign in_stall = (state_r != ST_IDLE);

  assign res_item.first_index = offset_r + POS_W'(cursor_r);
  assign res_item.end_index   = offset_r + POS_W'(lo_r);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    phase_nxt  = phase_r;
    lo_nxt     = lo_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    stop_nxt   = stop_r;
    offset_nxt = offset_r;
    ram_req       = '0;
    ram_req.waddr = count_r[ADDR_W-1:0];
    ram_req.wdata = in_item.position_value;
    ram_req.raddr = mid[ADDR_W-1:0];
    res_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_item.operation)
            OP_CLEAR: begin
              count_nxt  = '0;
              cursor_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                ram_req.we = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              lo_nxt     = cursor_r;
              len_nxt    = count_r - cursor_r;
              key_nxt    = in_item.range_start;
              stop_nxt   = in_item.range_stop;
              offset_nxt = in_item.index_offset;
              phase_nxt  = 1'b0;
              state_nxt  = ST_LOOP;
            end
            default: ;
          endcase
        end
      end
      ST_LOOP: begin
        if (len_r != '0) begin
          // fetch the midpoint entry
          ram_req.re = 1'b1;
          state_nxt  = ST_CMP;
        end else if (!phase_r) begin
          // start search done, launch stop search from the new cursor
          cursor_nxt = lo_r;
          len_nxt    = count_r - lo_r;
          key_nxt    = stop_r;
          phase_nxt  = 1'b1;
        end else begin
          res_valid = 1'b1;
          if (res_ready) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        // narrow the interval on the fetched entry
        if (ram_rdata < key_r) begin
          lo_nxt  = mid + 1'b1;
          len_nxt = len_r - half - 1'b1;
        end else begin
          len_nxt = half;
        end
        state_nxt = ST_LOOP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    len_r    <= len_nxt;
    key_r    <= key_nxt;
    stop_r   <= stop_nxt;
    offset_r <= offset_nxt;
  end

  `SPQ_ASSERT_NOW(a_cursor_in_table, clk, rst_n, 1'b1, cursor_r <= count_r,
    "search cursor beyond entry count")
  `SPQ_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(TABLE_DEPTH),
    "entry count beyond table depth")
  `SPQ_ASSERT_NOW(a_interval_in_table, clk, rst_n, state_r != ST_IDLE,
    lo_plus_len <= {1'b0, count_r}, "search interval runs past entry count")
  `SPQ_ASSERT_NEXT(a_cmp_after_read, clk, rst_n, ram_req.re, state_r == ST_CMP,
    "read issued without compare step")

endmodule

// File: sv/sorted_position_range_query.sv
`timescale 1ns / 1ps
// sorted position range query
// in channel: in_valid / in_stall / in_item. operation clear empties the table
// and the cursor, append stores position_value at the end of the table (dropped
// when full), query looks up range_start and range_stop and returns one item.
// out channel: out_valid / out_stall / out_item with first_index and end_index,
// both offset by index_offset modulo 2^32. clear and append give no item.
// clear and append leave in_stall low. a query holds in_stall high while two
// lower-bound searches run on one compare unit against the table memory (one
// write port, one read port): each bisection step is a memory read in ST_LOOP
// followed by a compare in ST_CMP.
// the result sits in an output register; while out_stall is high it holds,
// and a finished query waits for that register before the block takes the
// next item. clear and append are still taken while a result waits.
// reset (rst_n low, synchronous) empties the table and the cursor and drops
// any pending result; table contents are not cleared and need no sweep.
module sorted_position_range_query (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  spq_ram_req_t ram_req;
  logic [POS_W-1:0] ram_rdata;
  logic         res_valid;
  logic         res_ready;
  spq_out_t     res_item;
  logic         out_valid_r, out_valid_nxt;
  spq_out_t     out_item_r;

  spq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  spq_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (POS_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sim/tb_sorted_position_range_query.sv
`timescale 1ns / 1ps
module tb_sorted_position_range_query;
  import spq_pkg::*;

  // operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] ALL1 = '1;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 200;
  localparam longint TIMEOUT_NS = 64'd30_000_000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    spq_in_t  item;
    logic     known;
    spq_out_t bounds;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  spq_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_item;

  // predictor copy of the table, its fill level and the search cursor
  logic [POS_W-1:0] pos_table [TABLE_DEPTH];
  logic [CNT_W-1:0] pos_count = '0;
  logic [CNT_W-1:0] cursor = '0;
  spq_out_t         bounds_queue [$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   pressure_req = 1'b0;
  logic hold_off = 1'b0;
  int   errors = 0;
  int   items_sent = 0;
  int   queries_sent = 0;
  int   bounds_seen = 0;

  always #5 clk = ~clk;

  sorted_position_range_query u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (errors < MAX_PRINTS)
      $display("%0t ns mismatch: %s expected %h got %h", $time, what, want, got);
    errors++;
  endtask

  // lower-bound bisection over [lo, pos_count)
  function automatic logic [CNT_W-1:0] lower_bound_index(logic [CNT_W-1:0] lo,
                                                        logic [POS_W-1:0] key);
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] mid;
    if (lo > pos_count) lo = pos_count;
    span = pos_count - lo;
    while (span != 0) begin
      half = span >> 1;
      mid  = lo + half;
      if (pos_table[mid[ADDR_W-1:0]] < key) begin
        lo   = mid + 1'b1;
        span = span - half - 1'b1;
      end else begin
        span = half;
      end
    end
    return lo;
  endfunction

  // update table state for one item and work out its index pair
  task automatic predict_item(input spq_in_t it, output bit has_bounds,
                              output spq_out_t bounds);
    logic [CNT_W-1:0] stop_idx;
    has_bounds = 1'b0;
    bounds     = '0;
    case (it.operation)
      OP_CLEAR: begin
        pos_count = '0;
        cursor    = '0;
      end
      OP_APPEND: begin
        if (pos_count < TABLE_DEPTH) begin
          pos_table[pos_count[ADDR_W-1:0]] = it.position_value;
          pos_count = pos_count + 1'b1;
        end
      end
      OP_QUERY: begin
        cursor   = lower_bound_index(cursor, it.range_start);
        stop_idx = lower_bound_index(cursor, it.range_stop);
        bounds.first_index = it.index_offset + 32'(cursor);
        bounds.end_index   = it.index_offset + 32'(stop_idx);
        has_bounds = 1'b1;
      end
      default: ;
    endcase
  endtask

  // offer one item, wait for it to be taken, then predict
  task automatic send_item(spq_in_t it, logic known, spq_out_t known_bounds);
    bit       has_bounds;
    spq_out_t bounds;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it, has_bounds, bounds);
    if (has_bounds) begin
      bounds_queue.insert(bounds_queue.size(), known ? known_bounds : bounds);
      queries_sent++;
    end
    if (it.operation != OP_UNUSED) items_sent++;
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] pos, logic [31:0] start,
                         logic [31:0] stop, logic [31:0] offset);
    spq_in_t it;
    it = '{operation: op, position_value: pos, range_start: start,
           range_stop: stop, index_offset: offset};
    send_item(it, 1'b0, '0);
  endtask

  function automatic plan_row_t plan_row(logic [1:0] op, logic [31:0] pos,
                                         logic [31:0] start, logic [31:0] stop,
                                         logic [31:0] offset, logic known,
                                         logic [31:0] first_idx, logic [31:0] end_idx);
    plan_row_t r;
    r.item   = '{operation: op, position_value: pos, range_start: start,
                 range_stop: stop, index_offset: offset};
    r.known  = known;
    r.bounds = '{first_index: first_idx, end_index: end_idx};
    return r;
  endfunction

  // search key near a stored entry, or anywhere
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    int unsigned idx;
    if (pos_count == 0 || $urandom_range(9) < 2) return $urandom();
    idx = $urandom_range(int'(pos_count) - 1, 0);
    k = pos_table[idx[ADDR_W-1:0]];
    case ($urandom_range(2, 0))
      0:       return k;
      1:       return k + 1;
      default: return k - 1;
    endcase
  endfunction

  // mostly clear, ascending appends and queries; the rest random noise
  task automatic run_sequence();
    int          n_app;
    int          n_q;
    int          shift;
    logic [31:0] pos;
    logic [31:0] step;
    logic [31:0] start;
    logic [31:0] stop;
    logic [31:0] offset;
    if ($urandom_range(99) < 80) begin
      send_op(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
      n_app = ($urandom_range(19, 0) == 0) ? $urandom_range(400, 100)
                                            : $urandom_range(40, 0);
      shift = $urandom_range(28, 0);
      pos   = $urandom() >> $urandom_range(31, 0);
      for (int i = 0; i < n_app; i++) begin
        send_op(OP_APPEND, pos, $urandom(), $urandom(), $urandom());
        step = $urandom_range(1 << shift, 0);
        pos  = (pos + step < pos) ? ALL1 : pos + step;
      end
      n_q = $urandom_range(8, 1);
      for (int i = 0; i < n_q; i++) begin
        start  = pick_key();
        stop   = ($urandom_range(3, 0) == 0) ? pick_key()
                                              : start + ($urandom() >> $urandom_range(31, 0));
        offset = ($urandom_range(1, 0) == 0) ? $urandom() : $urandom_range(1000, 0);
        send_op(OP_QUERY, $urandom(), start, stop, offset);
      end
    end else begin
      n_q = $urandom_range(6, 1);
      for (int i = 0; i < n_q; i++)
        send_op(2'($urandom_range(3, 0)), $urandom(), pick_key(), pick_key(), $urandom());
    end
  endtask

  // receiver: check each taken result, stall at random or while held off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      bounds_seen++;
      if (bounds_queue.size() == 0) begin
        report_mismatch("result with no query waiting", '0, out_item.first_index);
      end else begin
        if (out_item.first_index != bounds_queue[0].first_index)
          report_mismatch("first_index", bounds_queue[0].first_index, out_item.first_index);
        if (out_item.end_index != bounds_queue[0].end_index)
          report_mismatch("end_index", bounds_queue[0].end_index, out_item.end_index);
        void'(bounds_queue.pop_front());
      end
    end
    out_stall <= rst_n && (hold_off || ($urandom_range(99) < recv_idle_pct));
  end

  // long receiver hold-off so the output register fills and input stalls
  initial begin
    wait (pressure_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL sorted_position_range_query");
    $finish;
  end

  initial begin
    plan_row_t steps [$];
    int        target;
    int        waited;

    steps = '{
      // empty table after reset
      plan_row(OP_QUERY,  0,      0,      ALL1,   0,    1'b1, 0,    0),
      plan_row(OP_QUERY,  ALL1,   ALL1,   0,      ALL1, 1'b1, ALL1, ALL1),
      plan_row(OP_UNUSED, ALL1,   ALL1,   ALL1,   ALL1, 1'b0, 0,    0),
      // sorted table with both extremes
      plan_row(OP_APPEND, 0,      ALL1,   ALL1,   ALL1, 1'b0, 0,    0),
      plan_row(OP_APPEND, 'h10,   0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_APPEND, 'h20,   ALL1,   0,      ALL1, 1'b0, 0,    0),
      plan_row(OP_APPEND, ALL1,   0,      ALL1,   0,    1'b0, 0,    0),
      plan_row(OP_QUERY,  ALL1,   0,      ALL1,   0,    1'b1, 0,    3),
      plan_row(OP_QUERY,  0,      'h11,   'h20,   0,    1'b0, 0,    0),
      // stop below start
      plan_row(OP_QUERY,  0,      'h20,   'h05,   100,  1'b0, 0,    0),
      // start behind the cursor
      plan_row(OP_QUERY,  0,      0,      ALL1,   'h8000_0000, 1'b0, 0, 0),
      plan_row(OP_QUERY,  0,      ALL1,   ALL1,   ALL1, 1'b0, 0,    0),
      plan_row(OP_CLEAR,  ALL1,   ALL1,   ALL1,   ALL1, 1'b0, 0,    0),
      plan_row(OP_QUERY,  0,      ALL1,   ALL1,   5,    1'b1, 5,    5),
      // unsorted table
      plan_row(OP_APPEND, 50,     0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_APPEND, 10,     0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_APPEND, 40,     0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_APPEND, 5,      0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_QUERY,  0,      20,     45,     0,    1'b0, 0,    0),
      plan_row(OP_QUERY,  0,      0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_UNUSED, 0,      0,      0,      0,    1'b0, 0,    0),
      plan_row(OP_CLEAR,  0,      0,      0,      0,    1'b0, 0,    0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender rarely idles, receiver mostly stalls
    send_idle_pct = 7;
    recv_idle_pct = 74;
    foreach (steps[i]) send_item(steps[i].item, steps[i].known, steps[i].bounds);

    target = items_sent + RANDOM_ITEMS / 3;
    while (items_sent < target) run_sequence();

    // phase two: roles swapped
    send_idle_pct = 74;
    recv_idle_pct = 7;
    target = items_sent + RANDOM_ITEMS / 3;
    while (items_sent < target) run_sequence();

    // phase three: no idling, with one long receiver hold-off at its start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_req  = 1'b1;
    target = items_sent + RANDOM_ITEMS / 3;
    while (items_sent < target) run_sequence();
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    waited = 0;
    while (bounds_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bounds_queue.size() != 0)
      report_mismatch("queries still without a result", '0, bounds_queue.size());

    $display("ran %0d items, %0d query results over sorted, unsorted and empty tables",
             items_sent, bounds_seen);
    $display("idle mixes 7/74, 74/7 and 0/0 percent plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0)
      $display("PASS sorted_position_range_query");
    else
      $display("FAIL sorted_position_range_query");
    $finish;
  end

endmodule
